>>> sv/rti_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/triangle core.
// No dependencies; imported by rti_div, ray_triangle_intersect_core and tb.
package rti_pkg;

    // Request codes
    localparam logic [1:0] CMD_VERTEX    = 2'd0;
    localparam logic [1:0] CMD_INDEX     = 2'd1;
    localparam logic [1:0] CMD_INTERSECT = 2'd2;
    localparam logic [1:0] CMD_OCCLUDE   = 2'd3;

    // Divider geometry: 50-bit magnitudes, 32 quotient bits, 16 of them fraction
    localparam int DIV_W  = 50;
    localparam int QUO_W  = 32;
    localparam int FRAC_W = 16;

    // Ray carried down the pipeline
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] near_lim;
        logic signed [31:0] far_lim;
    } ray_t;

    // Sideband that travels alongside the divider
    typedef struct packed {
        logic               ok;
        logic               occl;
        logic               neg;
        logic               ovf;
        logic signed [31:0] near_lim;
        logic signed [31:0] far_lim;
    } rti_side_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x > 50'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Q16.16 product, floor toward minus infinity, kept at 48 bits
    function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:16];
    endfunction

endpackage

>>> sv/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q16.16 result.
// Depends on rti_pkg (widths and sideband type).
module rti_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_vld,
    input  logic [49:0]          num,
    input  logic [49:0]          den,
    input  rti_pkg::rti_side_t   in_side,
    output logic                 out_vld,
    output logic [31:0]          quo,
    output rti_pkg::rti_side_t   out_side
);
    import rti_pkg::*;

    logic [DIV_W-1:0] rem_reg  [QUO_W];
    logic [DIV_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] low_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    rti_side_t        side_reg [QUO_W];
    logic [QUO_W-1:0] vld_reg;

    logic [DIV_W-1:0] rem_in  [QUO_W];
    logic [DIV_W-1:0] den_in  [QUO_W];
    logic [QUO_W-1:0] low_in  [QUO_W];
    logic [QUO_W-1:0] quo_in  [QUO_W];
    rti_side_t        side_in [QUO_W];
    logic [DIV_W:0]   trial   [QUO_W];
    logic [DIV_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] ge;

    // Stage inputs: first stage from the ports, others from the stage before
    genvar i;
    generate
        for (i = 0; i < QUO_W; i++) begin : g_stage
            if (i == 0) begin : g_first
                assign rem_in[i]  = {{FRAC_W{1'b0}}, num[DIV_W-1:FRAC_W]};
                assign den_in[i]  = den;
                assign low_in[i]  = {num[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
                assign quo_in[i]  = '0;
                assign side_in[i] = in_side;
            end else begin : g_rest
                assign rem_in[i]  = rem_reg[i-1];
                assign den_in[i]  = den_reg[i-1];
                assign low_in[i]  = low_reg[i-1];
                assign quo_in[i]  = quo_reg[i-1];
                assign side_in[i] = side_reg[i-1];
            end
            // shift in the next dividend bit, compare and subtract
            assign trial[i]    = {rem_in[i], low_in[i][QUO_W-1]};
            assign ge[i]       = (trial[i] >= {1'b0, den_in[i]});
            assign rem_next[i] = ge[i] ? DIV_W'(trial[i] - {1'b0, den_in[i]})
                                       : trial[i][DIV_W-1:0];
        end
    endgenerate

    // Stage payload registers
    always_ff @(posedge clk) begin
        if (adv) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_in[k];
                low_reg[k]  <= {low_in[k][QUO_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[k][QUO_W-2:0], ge[k]};
                side_reg[k] <= side_in[k];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_vld};
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quo      = quo_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

endmodule

>>> sv/ray_triangle_intersect_core.sv
// Ray/triangle intersection core: vertex and index tables, Moller-Trumbore pipeline.
// Depends on rti_pkg and rti_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per cycle while in_stall is low:
//   vertex write, index write, intersect test or occlusion test. Writes take effect at
//   once and give no result; tests see every write accepted before them.
//   Output channel (out_valid / out_stall) returns one hit/distance per test, in
//   order. det_epsilon is written through det_epsilon_we / det_epsilon_wdata.
//   Throughput: one request per cycle, sustained while out_stall does not hold the pipeline.
//   Pipeline: 42 register stages from the accepting edge to out_valid:
//   table reads (2), edges and cross products (3), dot products and sign fixup (3),
//   barycentric bounds (1), a 32-stage one-bit-per-stage divider for the distance,
//   and the output register.
//   Stall: when out_valid is high and out_stall is asserted, the whole pipeline
//   freezes and in_stall goes high the same cycle; nothing is dropped or repeated.
//   Reset: clears all valid bits and sets det_epsilon to 1; table contents are
//   undefined until written.
//   Tables are plain RAMs: the index table is split in three banks (position mod 3)
//   and the vertex table is held in three copies, so one test reads all three
//   corners in parallel.
module ray_triangle_intersect_core #(
    parameter int VERTEX_DEPTH   = 1024,
    parameter int TRIANGLE_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               det_epsilon_we,
    input  logic [15:0]        det_epsilon_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [11:0]        slot,
    input  logic [9:0]         vertex_ref,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] near_limit,
    input  logic signed [31:0] far_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] distance
);
    import rti_pkg::*;

    localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int TAW = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
    localparam int NSTG = 9;

    // Global advance: whole pipeline moves unless a held result is stalled
    logic adv;
    logic acc;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // Threshold register
    logic [15:0] eps_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            eps_reg <= 16'd1;
        end else if (det_epsilon_we) begin
            eps_reg <= det_epsilon_wdata;
        end
    end

    // Request decode
    logic [31:0] slot_ext;
    logic [23:0] div3_prod;
    logic [10:0] q0;
    logic [11:0] q0x3;
    logic [11:0] r0;
    logic        r_fix;
    logic [10:0] iq;
    logic [11:0] ir_full;
    logic [1:0]  ir;
    logic [31:0] iq_ext;
    logic        iw_en;
    logic        vw_en;
    logic [TAW-1:0] iw_addr;
    logic [TAW-1:0] ir_addr;
    logic [VAW-1:0] vw_addr;
    logic [95:0] vw_data;

    assign slot_ext  = {20'd0, slot};
    // slot / 3 by reciprocal multiply with one correction step
    assign div3_prod = 24'(slot) * 24'd2731;
    assign q0        = div3_prod[23:13];
    assign q0x3      = {q0, 1'b0} + {1'b0, q0};
    assign r0        = slot - q0x3;
    assign r_fix     = (r0 >= 12'd3);
    assign iq        = r_fix ? q0 + 11'd1 : q0;
    assign ir_full   = r_fix ? r0 - 12'd3 : r0;
    assign ir        = ir_full[1:0];
    assign iq_ext    = {21'd0, iq};
    assign iw_addr   = iq_ext[TAW-1:0];
    assign ir_addr   = slot_ext[TAW-1:0];
    assign vw_addr   = slot_ext[VAW-1:0];
    assign vw_data   = {pos_x, pos_y, pos_z};
    assign iw_en     = acc && (cmd == CMD_INDEX) && (slot_ext < 32'(3 * TRIANGLE_DEPTH));
    assign vw_en     = acc && (cmd == CMD_VERTEX) && (slot_ext < 32'(VERTEX_DEPTH));

    // Index table, three banks by position mod 3
    logic [9:0] idx_mem0 [TRIANGLE_DEPTH];
    logic [9:0] idx_mem1 [TRIANGLE_DEPTH];
    logic [9:0] idx_mem2 [TRIANGLE_DEPTH];
    logic [9:0] idx_rd0_reg;
    logic [9:0] idx_rd1_reg;
    logic [9:0] idx_rd2_reg;

    always_ff @(posedge clk) begin
        if (iw_en && ir == 2'd0) begin
            idx_mem0[iw_addr] <= vertex_ref;
        end
        if (adv) begin
            idx_rd0_reg <= idx_mem0[ir_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (iw_en && ir == 2'd1) begin
            idx_mem1[iw_addr] <= vertex_ref;
        end
        if (adv) begin
            idx_rd1_reg <= idx_mem1[ir_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (iw_en && ir == 2'd2) begin
            idx_mem2[iw_addr] <= vertex_ref;
        end
        if (adv) begin
            idx_rd2_reg <= idx_mem2[ir_addr];
        end
    end

    // Vertex table, three identical copies (one read port per corner)
    logic [31:0] vi0_ext;
    logic [31:0] vi1_ext;
    logic [31:0] vi2_ext;
    logic [VAW-1:0] va0;
    logic [VAW-1:0] va1;
    logic [VAW-1:0] va2;
    assign vi0_ext = {22'd0, idx_rd0_reg};
    assign vi1_ext = {22'd0, idx_rd1_reg};
    assign vi2_ext = {22'd0, idx_rd2_reg};
    assign va0     = vi0_ext[VAW-1:0];
    assign va1     = vi1_ext[VAW-1:0];
    assign va2     = vi2_ext[VAW-1:0];

    logic [95:0] vtx_mem0 [VERTEX_DEPTH];
    logic [95:0] vtx_mem1 [VERTEX_DEPTH];
    logic [95:0] vtx_mem2 [VERTEX_DEPTH];
    logic [95:0] vtx_rd0_reg;
    logic [95:0] vtx_rd1_reg;
    logic [95:0] vtx_rd2_reg;

    always_ff @(posedge clk) begin
        if (vw_en) begin
            vtx_mem0[vw_addr] <= vw_data;
        end
        if (adv) begin
            vtx_rd0_reg <= vtx_mem0[va0];
        end
    end

    always_ff @(posedge clk) begin
        if (vw_en) begin
            vtx_mem1[vw_addr] <= vw_data;
        end
        if (adv) begin
            vtx_rd1_reg <= vtx_mem1[va1];
        end
    end

    always_ff @(posedge clk) begin
        if (vw_en) begin
            vtx_mem2[vw_addr] <= vw_data;
        end
        if (adv) begin
            vtx_rd2_reg <= vtx_mem2[va2];
        end
    end

    // Valid bits of the front stages
    logic [NSTG-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0],
                        acc && ((cmd == CMD_INTERSECT) || (cmd == CMD_OCCLUDE))};
        end
    end

    // Stage 1: capture ray and triangle range check
    ray_t s1_ray_reg;
    logic s1_occl_reg;
    logic s1_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s1_ray_reg  <= {pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, near_limit, far_limit};
            s1_occl_reg <= (cmd == CMD_OCCLUDE);
            s1_ok_reg   <= (slot_ext < 32'(TRIANGLE_DEPTH));
        end
    end

    // Stage 2: vertex numbers range check (vertex data lands in vtx_rd*_reg)
    ray_t s2_ray_reg;
    logic s2_occl_reg;
    logic s2_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s2_ray_reg  <= s1_ray_reg;
            s2_occl_reg <= s1_occl_reg;
            s2_ok_reg   <= s1_ok_reg && (vi0_ext < 32'(VERTEX_DEPTH))
                           && (vi1_ext < 32'(VERTEX_DEPTH)) && (vi2_ext < 32'(VERTEX_DEPTH));
        end
    end

    // Stage 3: edges and origin offset, saturated
    logic signed [31:0] v0 [3];
    logic signed [31:0] v1 [3];
    logic signed [31:0] v2 [3];
    logic signed [31:0] org [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v0[k] = vtx_rd0_reg[95-32*k -: 32];
            v1[k] = vtx_rd1_reg[95-32*k -: 32];
            v2[k] = vtx_rd2_reg[95-32*k -: 32];
        end
        org[0] = s2_ray_reg.ox;
        org[1] = s2_ray_reg.oy;
        org[2] = s2_ray_reg.oz;
    end

    logic signed [31:0] s3_e1_reg [3];
    logic signed [31:0] s3_e2_reg [3];
    logic signed [31:0] s3_tv_reg [3];
    ray_t s3_ray_reg;
    logic s3_occl_reg;
    logic s3_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                s3_e1_reg[k] <= sat32(50'(v1[k]) - 50'(v0[k]));
                s3_e2_reg[k] <= sat32(50'(v2[k]) - 50'(v0[k]));
                s3_tv_reg[k] <= sat32(50'(org[k]) - 50'(v0[k]));
            end
            s3_ray_reg  <= s2_ray_reg;
            s3_occl_reg <= s2_occl_reg;
            s3_ok_reg   <= s2_ok_reg;
        end
    end

    // Stage 4: cross-product partial products, P = dir x e2, Q = tv x e1
    logic signed [31:0] s3_dir [3];
    assign s3_dir[0] = s3_ray_reg.dx;
    assign s3_dir[1] = s3_ray_reg.dy;
    assign s3_dir[2] = s3_ray_reg.dz;

    logic signed [47:0] s4_ppa_reg [3];
    logic signed [47:0] s4_ppb_reg [3];
    logic signed [47:0] s4_qpa_reg [3];
    logic signed [47:0] s4_qpb_reg [3];
    logic signed [31:0] s4_e1_reg [3];
    logic signed [31:0] s4_e2_reg [3];
    logic signed [31:0] s4_tv_reg [3];
    ray_t s4_ray_reg;
    logic s4_occl_reg;
    logic s4_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s4_ppa_reg[0] <= qmul(s3_dir[1], s3_e2_reg[2]);
            s4_ppb_reg[0] <= qmul(s3_dir[2], s3_e2_reg[1]);
            s4_ppa_reg[1] <= qmul(s3_dir[2], s3_e2_reg[0]);
            s4_ppb_reg[1] <= qmul(s3_dir[0], s3_e2_reg[2]);
            s4_ppa_reg[2] <= qmul(s3_dir[0], s3_e2_reg[1]);
            s4_ppb_reg[2] <= qmul(s3_dir[1], s3_e2_reg[0]);
            s4_qpa_reg[0] <= qmul(s3_tv_reg[1], s3_e1_reg[2]);
            s4_qpb_reg[0] <= qmul(s3_tv_reg[2], s3_e1_reg[1]);
            s4_qpa_reg[1] <= qmul(s3_tv_reg[2], s3_e1_reg[0]);
            s4_qpb_reg[1] <= qmul(s3_tv_reg[0], s3_e1_reg[2]);
            s4_qpa_reg[2] <= qmul(s3_tv_reg[0], s3_e1_reg[1]);
            s4_qpb_reg[2] <= qmul(s3_tv_reg[1], s3_e1_reg[0]);
            s4_e1_reg     <= s3_e1_reg;
            s4_e2_reg     <= s3_e2_reg;
            s4_tv_reg     <= s3_tv_reg;
            s4_ray_reg    <= s3_ray_reg;
            s4_occl_reg   <= s3_occl_reg;
            s4_ok_reg     <= s3_ok_reg;
        end
    end

    // Stage 5: cross products, saturated per component
    logic signed [31:0] s5_p_reg [3];
    logic signed [31:0] s5_q_reg [3];
    logic signed [31:0] s5_e1_reg [3];
    logic signed [31:0] s5_e2_reg [3];
    logic signed [31:0] s5_tv_reg [3];
    ray_t s5_ray_reg;
    logic s5_occl_reg;
    logic s5_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                s5_p_reg[k] <= sat32(50'(s4_ppa_reg[k]) - 50'(s4_ppb_reg[k]));
                s5_q_reg[k] <= sat32(50'(s4_qpa_reg[k]) - 50'(s4_qpb_reg[k]));
            end
            s5_e1_reg   <= s4_e1_reg;
            s5_e2_reg   <= s4_e2_reg;
            s5_tv_reg   <= s4_tv_reg;
            s5_ray_reg  <= s4_ray_reg;
            s5_occl_reg <= s4_occl_reg;
            s5_ok_reg   <= s4_ok_reg;
        end
    end

    // Stage 6: dot-product terms
    logic signed [31:0] s5_dir [3];
    assign s5_dir[0] = s5_ray_reg.dx;
    assign s5_dir[1] = s5_ray_reg.dy;
    assign s5_dir[2] = s5_ray_reg.dz;

    logic signed [47:0] s6_det_reg [3];
    logic signed [47:0] s6_nu_reg [3];
    logic signed [47:0] s6_nv_reg [3];
    logic signed [47:0] s6_nt_reg [3];
    ray_t s6_ray_reg;
    logic s6_occl_reg;
    logic s6_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                s6_det_reg[k] <= qmul(s5_e1_reg[k], s5_p_reg[k]);
                s6_nu_reg[k]  <= qmul(s5_tv_reg[k], s5_p_reg[k]);
                s6_nv_reg[k]  <= qmul(s5_dir[k], s5_q_reg[k]);
                s6_nt_reg[k]  <= qmul(s5_e2_reg[k], s5_q_reg[k]);
            end
            s6_ray_reg  <= s5_ray_reg;
            s6_occl_reg <= s5_occl_reg;
            s6_ok_reg   <= s5_ok_reg;
        end
    end

    // Stage 7: sums
    logic signed [49:0] s7_det_reg;
    logic signed [49:0] s7_nu_reg;
    logic signed [49:0] s7_nv_reg;
    logic signed [49:0] s7_nt_reg;
    ray_t s7_ray_reg;
    logic s7_occl_reg;
    logic s7_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s7_det_reg  <= 50'(s6_det_reg[0]) + 50'(s6_det_reg[1]) + 50'(s6_det_reg[2]);
            s7_nu_reg   <= 50'(s6_nu_reg[0]) + 50'(s6_nu_reg[1]) + 50'(s6_nu_reg[2]);
            s7_nv_reg   <= 50'(s6_nv_reg[0]) + 50'(s6_nv_reg[1]) + 50'(s6_nv_reg[2]);
            s7_nt_reg   <= 50'(s6_nt_reg[0]) + 50'(s6_nt_reg[1]) + 50'(s6_nt_reg[2]);
            s7_ray_reg  <= s6_ray_reg;
            s7_occl_reg <= s6_occl_reg;
            s7_ok_reg   <= s6_ok_reg;
        end
    end

    // Stage 8: parallel-ray reject and sign fixup so det is positive
    logic        det_neg;
    logic [49:0] abs_det;
    assign det_neg = s7_det_reg[49];
    assign abs_det = det_neg ? 50'(-s7_det_reg) : s7_det_reg;

    logic [49:0]        s8_det_reg;
    logic signed [49:0] s8_nu_reg;
    logic signed [49:0] s8_nv_reg;
    logic signed [49:0] s8_nt_reg;
    ray_t s8_ray_reg;
    logic s8_occl_reg;
    logic s8_ok_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s8_det_reg  <= abs_det;
            s8_nu_reg   <= det_neg ? -s7_nu_reg : s7_nu_reg;
            s8_nv_reg   <= det_neg ? -s7_nv_reg : s7_nv_reg;
            s8_nt_reg   <= det_neg ? -s7_nt_reg : s7_nt_reg;
            s8_ray_reg  <= s7_ray_reg;
            s8_occl_reg <= s7_occl_reg;
            s8_ok_reg   <= s7_ok_reg && (s7_det_reg != 50'sd0)
                           && (abs_det >= {34'd0, eps_reg});
        end
    end

    // Stage 9: barycentric bounds on numerators, divider operands
    logic signed [50:0] nu51;
    logic signed [50:0] nv51;
    logic signed [50:0] det51;
    logic               bary_ok;
    logic               nt_neg;
    logic [49:0]        nt_abs;
    logic               t_ovf;
    assign nu51    = 51'(s8_nu_reg);
    assign nv51    = 51'(s8_nv_reg);
    assign det51   = $signed({1'b0, s8_det_reg});
    assign bary_ok = !nu51[50] && (nu51 <= det51) && !nv51[50] && (nv51 <= det51)
                     && ((nu51 + nv51) <= det51);
    assign nt_neg  = s8_nt_reg[49];
    assign nt_abs  = nt_neg ? 50'(-s8_nt_reg) : s8_nt_reg;
    // integer part of the quotient would not fit 16 bits
    assign t_ovf   = ({16'd0, nt_abs} >= {s8_det_reg, 16'd0});

    logic [49:0] s9_num_reg;
    logic [49:0] s9_den_reg;
    rti_side_t   s9_side_reg;
    always_ff @(posedge clk) begin
        if (adv) begin
            s9_num_reg           <= nt_abs;
            s9_den_reg           <= s8_det_reg;
            s9_side_reg.ok       <= s8_ok_reg && bary_ok;
            s9_side_reg.occl     <= s8_occl_reg;
            s9_side_reg.neg      <= nt_neg;
            s9_side_reg.ovf      <= t_ovf;
            s9_side_reg.near_lim <= s8_ray_reg.near_lim;
            s9_side_reg.far_lim  <= s8_ray_reg.far_lim;
        end
    end

    // Distance divider
    logic        div_vld;
    logic [31:0] div_quo;
    rti_side_t   div_side;
    rti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (vld_reg[NSTG-1]),
        .num      (s9_num_reg),
        .den      (s9_den_reg),
        .in_side  (s9_side_reg),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .out_side (div_side)
    );

    // Final: sign, saturation, limit check
    logic signed [31:0] t_val;
    logic               hit_next;
    always_comb begin
        if (div_side.ovf) begin
            t_val = div_side.neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (div_side.neg) begin
            t_val = (div_quo > 32'h80000000) ? 32'sh80000000 : -$signed(div_quo);
        end else begin
            t_val = div_quo[31] ? 32'sh7fffffff : $signed(div_quo);
        end
        hit_next = div_side.ok && (t_val >= div_side.near_lim)
                   && (t_val <= div_side.far_lim);
    end

    // Output register
    logic               hit_reg;
    logic signed [31:0] distance_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            hit_reg      <= hit_next;
            distance_reg <= (hit_next && !div_side.occl) ? t_val : 32'sd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign distance  = distance_reg;

endmodule

>>> tb/tb.sv
// Testbench for ray_triangle_intersect_core: table writes, intersect and occlusion requests.
// Depends on rti_pkg and the core RTL; holds its own fixed-point model of the expected hits.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rti_pkg::*;

    localparam int  ONE      = 65536;
    localparam int  VTX_N    = 1024;
    localparam int  TRI_N    = 1024;
    localparam int  SMAX     = 32'sh7fffffff;
    localparam int  SMIN     = 32'sh80000000;

    typedef struct {
        logic [1:0]         cmd;
        logic [11:0]        slot;
        logic [9:0]         vref;
        logic signed [31:0] px, py, pz, dx, dy, dz, nl, fl;
        bit                 typed;
        logic               ehit;
        logic signed [31:0] edist;
    } req_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] dist_val;
    } hit_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               det_epsilon_we = 0;
    logic [15:0]        det_epsilon_wdata = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_VERTEX;
    logic [11:0]        slot = 0;
    logic [9:0]         vertex_ref = 0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
    logic signed [31:0] near_limit = 0, far_limit = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic               hit;
    logic signed [31:0] distance;

    // model state
    logic signed [31:0] vtx_tab [VTX_N][3];
    logic [9:0]         idx_tab [3*TRI_N];
    bit                 vtx_set [VTX_N];
    bit                 idx_set [3*TRI_N];
    longint             eps_cur = 1;

    hit_t   pending_hits[$];
    int     errors = 0;
    int     burst_left = 0;
    req_t   rows[$];

    ray_triangle_intersect_core DUT (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // fixed-point helpers
    function automatic longint sat_q(input longint x);
        if (x > longint'(SMAX)) return longint'(SMAX);
        if (x < longint'(SMIN)) return longint'(SMIN);
        return x;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic void cross_q(input longint a[3], input longint b[3],
                                    output longint r[3]);
        r[0] = sat_q(mul_q(a[1], b[2]) - mul_q(a[2], b[1]));
        r[1] = sat_q(mul_q(a[2], b[0]) - mul_q(a[0], b[2]));
        r[2] = sat_q(mul_q(a[0], b[1]) - mul_q(a[1], b[0]));
    endfunction

    function automatic longint dot_q(input longint a[3], input longint b[3]);
        return mul_q(a[0], b[0]) + mul_q(a[1], b[1]) + mul_q(a[2], b[2]);
    endfunction

    // num/den, truncated toward zero, saturated; den > 0
    function automatic longint div_q(input longint num, input longint den);
        bit                  neg;
        longint unsigned     n, d, q, r, m;
        neg = num < 0;
        n = neg ? -num : num;
        d = den;
        q = n / d;
        r = n % d;
        if (q >= 65536) return neg ? longint'(SMIN) : longint'(SMAX);
        m = q;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            m = m << 1;
            if (r >= d)
            begin
                r = r - d;
                m = m | 1;
            end
        end
        return sat_q(neg ? -longint'(m) : longint'(m));
    endfunction

    // update tables or work out the hit for one accepted request
    function automatic void predict_hit(input req_t r, output bit has_res, output hit_t res);
        longint org[3], dr[3], v[3][3], e1[3], e2[3], tv[3], pp[3], qq[3];
        longint det, nu, nv, nt, t;
        int     base;
        has_res = 0;
        res.hit = 0;
        res.dist_val = 0;
        if (r.cmd == CMD_VERTEX)
        begin
            if (r.slot < VTX_N)
            begin
                vtx_tab[r.slot] = '{r.px, r.py, r.pz};
                vtx_set[r.slot] = 1;
            end
            return;
        end
        if (r.cmd == CMD_INDEX)
        begin
            if (r.slot < 3*TRI_N)
            begin
                idx_tab[r.slot] = r.vref;
                idx_set[r.slot] = 1;
            end
            return;
        end
        has_res = 1;
        if (r.slot >= TRI_N) return;
        base = r.slot * 3;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = vtx_tab[idx_tab[base+i]][k];
        org = '{r.px, r.py, r.pz};
        dr  = '{r.dx, r.dy, r.dz};
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = sat_q(v[1][k] - v[0][k]);
            e2[k] = sat_q(v[2][k] - v[0][k]);
            tv[k] = sat_q(org[k] - v[0][k]);
        end
        cross_q(dr, e2, pp);
        det = dot_q(e1, pp);
        if (det == 0) return;
        if ((det < 0 ? -det : det) < eps_cur) return;
        nu = dot_q(tv, pp);
        cross_q(tv, e1, qq);
        nv = dot_q(dr, qq);
        nt = dot_q(e2, qq);
        if (det < 0)
        begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (nu < 0 || nu > det || nv < 0 || nv > det || nu + nv > det) return;
        t = div_q(nt, det);
        if (t < r.nl || t > r.fl) return;
        res.hit = 1;
        if (r.cmd == CMD_INTERSECT) res.dist_val = t[31:0];
    endfunction

    function automatic bit tri_ready(input int t);
        for (int i = 0; i < 3; i++)
            if (!idx_set[3*t+i] || !vtx_set[idx_tab[3*t+i]]) return 0;
        return 1;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    // drive one request at a falling edge, hold until accepted, with burst gaps
    task automatic send_req(input req_t r);
        bit   has_res;
        hit_t res;
        cmd = r.cmd; slot = r.slot; vertex_ref = r.vref;
        pos_x = r.px; pos_y = r.py; pos_z = r.pz;
        dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
        near_limit = r.nl; far_limit = r.fl;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        predict_hit(r, has_res, res);
        if (has_res)
        begin
            if (r.typed)
            begin
                res.hit = r.ehit;
                res.dist_val = r.edist;
            end
            pending_hits = {pending_hits, res};
        end
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    // every expected result in, then let the pipeline go quiet
    task automatic drain();
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_eps(input logic [15:0] val);
        det_epsilon_we = 1;
        det_epsilon_wdata = val;
        @(negedge clk);
        det_epsilon_we = 0;
        eps_cur = val;
    endtask

    function automatic void add_row(input logic [1:0] c, input int s, input int vr,
                                    input int px, input int py, input int pz,
                                    input int dx, input int dy, input int dz,
                                    input int nl, input int fl,
                                    input bit typed, input bit eh, input int ed);
        req_t r;
        r = '{c, s[11:0], vr[9:0], px, py, pz, dx, dy, dz, nl, fl, typed, eh, ed};
        rows = {rows, r};
    endfunction

    // random request, mostly well-formed rays aimed at loaded triangles
    function automatic req_t rand_req();
        req_t   r;
        int     sel, t, tries, vi;
        longint wa, wb, tgt, o;
        r = '{default: '0};
        sel = $urandom_range(0, 99);
        if (sel < 22)
        begin
            r.cmd = CMD_VERTEX;
            r.slot = 12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 63));
            r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
            if ($urandom_range(0, 9) == 0)
            begin
                r.px = $urandom; r.py = $urandom; r.pz = $urandom;
            end
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.nl = $urandom; r.fl = $urandom; r.vref = 10'($urandom);
            return r;
        end
        if (sel < 36)
        begin
            r.cmd = CMD_INDEX;
            r.slot = 12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 95));
            r.vref = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 63));
            r.px = $urandom; r.dz = $urandom; r.fl = $urandom;
            return r;
        end
        r.cmd = $urandom_range(0, 1) ? CMD_INTERSECT : CMD_OCCLUDE;
        t = -1;
        for (tries = 0; tries < 10 && t < 0; tries++)
        begin
            vi = $urandom_range(0, 31);
            if (tri_ready(vi)) t = vi;
        end
        if (t < 0 || $urandom_range(0, 9) == 0)
        begin
            r.slot = 12'($urandom_range(TRI_N, 4095));
            r.px = $urandom; r.py = $urandom; r.pz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.nl = $urandom; r.fl = $urandom; r.vref = 10'($urandom);
            return r;
        end
        r.slot = 12'(t);
        r.vref = 10'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            r.px = $urandom; r.py = $urandom; r.pz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.nl = $urandom; r.fl = $urandom;
            return r;
        end
        // aim at a point near or inside the triangle
        wa = $urandom_range(0, 75000);
        wb = $urandom_range(0, (wa > 65536) ? 10000 : 75000 - wa);
        for (int k = 0; k < 3; k++)
        begin
            tgt = vtx_tab[idx_tab[3*t]][k]
                + ((wa * (vtx_tab[idx_tab[3*t+1]][k] - vtx_tab[idx_tab[3*t]][k])
                  + wb * (vtx_tab[idx_tab[3*t+2]][k] - vtx_tab[idx_tab[3*t]][k])) >>> 16);
            o = sat_q(tgt + rand_coord());
            if (k == 0) begin r.px = 32'(o); r.dx = 32'(sat_q(tgt - o)); end
            if (k == 1) begin r.py = 32'(o); r.dy = 32'(sat_q(tgt - o)); end
            if (k == 2) begin r.pz = 32'(o); r.dz = 32'(sat_q(tgt - o)); end
        end
        r.nl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2*ONE) : 0;
        r.fl = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2*ONE) : SMAX;
        return r;
    endfunction

    // check results in order
    always @(posedge clk)
    begin
        hit_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b distance=%0d", $realtime, hit, distance);
                errors++;
            end
            else
            begin
                e = pending_hits.pop_front();
                if (hit !== e.hit || distance !== e.dist_val)
                begin
                    $display("%0t: mismatch expected hit=%0b distance=%0d, got hit=%0b distance=%0d",
                             $realtime, e.hit, e.dist_val, hit, distance);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off every fourth segment
    initial
    begin
        int seg, pct, len;
        seg = 0;
        @(posedge rst_n);
        forever
        begin
            seg++;
            len = $urandom_range(50, 300);
            pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            if (seg % 4 == 0)
            begin
                @(negedge clk);
                out_stall = 1;
                repeat (400) @(negedge clk);
            end
            else
            begin
                repeat (len)
                begin
                    @(negedge clk);
                    out_stall = ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #4ms;
        $display("tb failed");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [15:0] eps_list[4];
        int          per_phase;
        req_t        r;
        eps_list = '{16'd0, 16'hffff, 16'd0, 16'd1};
        eps_list[2] = 16'($urandom_range(2, 65534));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // unit triangle at vertices 0,1,2, rays through its edges and limits
        add_row(CMD_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_VERTEX, 1, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_VERTEX, 2, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INTERSECT, 0, 0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, SMAX, 1, 1, ONE);
        add_row(CMD_OCCLUDE, 0, 0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, SMAX, 1, 1, 0);
        add_row(CMD_INTERSECT, 0, 0, 2*ONE, 2*ONE, -ONE, 0, 0, ONE, 0, SMAX, 1, 0, 0);
        // parallel ray: zero determinant
        add_row(CMD_INTERSECT, 0, 0, ONE/4, ONE/4, -ONE, ONE, 0, 0, SMIN, SMAX, 1, 0, 0);
        // triangle numbers out of range
        add_row(CMD_INTERSECT, 4095, 0, 0, 0, 0, 0, 0, ONE, 0, SMAX, 1, 0, 0);
        add_row(CMD_OCCLUDE, TRI_N, 0, 0, 0, 0, 0, 0, ONE, 0, SMAX, 1, 0, 0);
        // inverted limits
        add_row(CMD_INTERSECT, 0, 0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 2*ONE, 0, 1, 0, 0);
        // limits inclusive at exactly t, then just short of it
        add_row(CMD_INTERSECT, 0, 0, ONE/4, ONE/4, -ONE, 0, 0, ONE, ONE, ONE, 1, 1, ONE);
        add_row(CMD_INTERSECT, 0, 0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, ONE-1, 1, 0, 0);
        // on the hypotenuse u+v == 1, then just past it
        add_row(CMD_INTERSECT, 0, 0, ONE/2, ONE/2, -ONE, 0, 0, ONE, 0, SMAX, 1, 1, ONE);
        add_row(CMD_INTERSECT, 0, 0, ONE/2, ONE/2+1, -ONE, 0, 0, ONE, 0, SMAX, 1, 0, 0);
        // extreme vertices, out-of-range writes, extreme ray
        add_row(CMD_VERTEX, 1023, 0, SMAX, SMAX, SMAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_VERTEX, 1022, 0, SMIN, SMIN, SMIN, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_VERTEX, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 3069, 1022, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 3070, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 3071, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INDEX, 4095, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INTERSECT, 1023, 0, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMAX,
                0, 0, 0);
        foreach (rows[i]) send_req(rows[i]);

        // random phases, each under its own threshold
        per_phase = 275;
        foreach (eps_list[p])
        begin
            in_valid = 0;
            drain();
            write_eps(eps_list[p]);
            for (int n = 0; n < per_phase; n++)
            begin
                r = rand_req();
                send_req(r);
            end
        end

        in_valid = 0;
        drain();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> ray_triangle_intersect_core.f
sv/rti_pkg.sv
sv/rti_div.sv
sv/ray_triangle_intersect_core.sv
tb/tb.sv
